>>> hdl/cpw_pkg.sv
// ----------------------------------------------------------------------------
// cpw_pkg
// Shared constants, register map and helpers for the corner-pin warp unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpw_pkg;

  // Frame store geometry
  localparam int unsigned MAX_WIDTH   = 128;
  localparam int unsigned MAX_HEIGHT  = 128;
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);
  localparam int unsigned STORE_AW    = COL_W + ROW_W;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // Field widths
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned DIM_W    = 8;
  localparam int unsigned CORNER_W = 64;
  localparam int unsigned HALF_W   = 32;

  // Configuration port
  localparam int unsigned APB_DW    = 64;
  localparam int unsigned PADDR_W   = 6;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_LSB   = 3;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = DIM_W'(128);
  localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = DIM_W'(128);
  localparam logic [CORNER_W-1:0] RST_CORNER_UL    = 64'h0000_0000_0000_0000;
  localparam logic [CORNER_W-1:0] RST_CORNER_UR    = 64'h0000_0000_0001_0000;
  localparam logic [CORNER_W-1:0] RST_CORNER_LL    = 64'h0001_0000_0000_0000;
  localparam logic [CORNER_W-1:0] RST_CORNER_LR    = 64'h0001_0000_0001_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_CORNER_UL    = 3'd2,
    REG_CORNER_UR    = 3'd3,
    REG_CORNER_LL    = 3'd4,
    REG_CORNER_LR    = 3'd5
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_e;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                              input logic [DIM_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  // x half in 31:0, y half in 63:32
  function automatic logic signed [HALF_W-1:0] corner_half(input logic [CORNER_W-1:0] r,
                                                          input logic sel_y);
    return sel_y ? $signed(r[CORNER_W-1:HALF_W]) : $signed(r[HALF_W-1:0]);
  endfunction

endpackage

`default_nettype wire

>>> hdl/corner_pin_bilinear_warp_unit.sv
// ----------------------------------------------------------------------------
// corner_pin_bilinear_warp_unit
// Corner-pin warp over a stored RGBA frame, with a registered output stage.
// ----------------------------------------------------------------------------
// A load transaction writes one pixel into the 128x128 frame store and
// returns ready straight away. An emit transaction maps the output position
// through the four Q16.16 corners and returns the stored pixel at the
// rounded, clamped source point; from acceptance to the result register it
// runs a prepare step, then per axis 6 multiply-accumulate steps on one
// shared multiplier, a rounding step, 0 or 7 steps of the bit-per-cycle
// divider and a clamp step; then a frame store read and an output load.
// Input is taken again once the result sits in the output register, so loads
// can go on while a result waits to be taken. The frame store holds no defined
// data until it is loaded; no clearing pass is run.
`default_nettype none

module corner_pin_bilinear_warp_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            opcode_i,
  input  logic [cpw_pkg::COL_W-1:0]       pos_x_i,
  input  logic [cpw_pkg::ROW_W-1:0]       pos_y_i,
  input  logic [cpw_pkg::PIX_W-1:0]       pixel_in_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cpw_pkg::PIX_W-1:0]       pixel_out_o,
  output logic [cpw_pkg::COL_W-1:0]       source_x_o,
  output logic [cpw_pkg::ROW_W-1:0]       source_y_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cpw_pkg::PADDR_W-1:0]     paddr,
  input  logic [cpw_pkg::APB_DW-1:0]      pwdata,
  output logic [cpw_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import cpw_pkg::*;

  localparam int unsigned COEF_W  = HALF_W + 2;
  localparam int unsigned FAC_W   = 2 * COL_W + 1;
  localparam int unsigned PROD_W  = COEF_W + FAC_W + 1;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned NUM_W   = ACC_W - FRAC_W;
  localparam int unsigned QUO_W   = COL_W;
  localparam int unsigned REM_W   = QUO_W + COL_W;
  localparam int unsigned DSH_W   = REM_W + 3;
  localparam int unsigned TERM_W  = 3;
  localparam int unsigned CNT_W   = $clog2(QUO_W);

  localparam logic [TERM_W-1:0] TERM_LAST  = TERM_W'(5);
  localparam logic [TERM_W-1:0] TERM_COUNT = TERM_W'(4);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // control
  logic [2:0]            state_q, state_d;
  logic                  ax_q, ax_d;           // 0: x axis, 1: y axis
  logic [TERM_W-1:0]     term_q, term_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;

  // configuration
  logic [DIM_W-1:0]      width_q, height_q;
  logic [CORNER_W-1:0]   corner_ul_q, corner_ur_q, corner_ll_q, corner_lr_q;

  // datapath
  logic [DIM_W-1:0]          w_q, w_d, h_q, h_d;
  logic [COL_W-1:0]          x_q, x_d;
  logic [ROW_W-1:0]          y_q, y_d;
  logic [FAC_W-1:0]          wh_q, wh_d, hx_q, hx_d, wy_q, wy_d, xy_q, xy_d;
  logic [FAC_W-1:0]          fac_q, fac_d;
  logic signed [COEF_W-1:0]  coef_q, coef_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [REM_W-1:0]          rem_q, rem_d;
  logic [QUO_W-1:0]          quo_q, quo_d;
  logic [COL_W-1:0]          sx_q, sx_d;
  logic [ROW_W-1:0]          sy_q, sy_d;
  logic [PIX_W-1:0]          rd_data_q;
  logic [PIX_W-1:0]          pixel_out_q, pixel_out_d;
  logic [COL_W-1:0]          source_x_q, source_x_d;
  logic [ROW_W-1:0]          source_y_q, source_y_d;

  logic [PIX_W-1:0]          frame_store_q [STORE_DEPTH];

  logic                      in_acc, cfg_we, mem_we, mem_re, out_load;
  reg_idx_e                  reg_idx;
  logic signed [HALF_W-1:0]  ul_s, ur_s, ll_s, lr_s;
  logic signed [COEF_W-1:0]  coef_sel;
  logic [FAC_W-1:0]          fac_sel;
  logic signed [PROD_W-1:0]  prod_mul;
  logic [DIM_W-1:0]          d_div, hi_lim;
  logic [ACC_W-1:0]          rnd;
  logic [NUM_W-1:0]          num;
  logic                      sat;
  logic [DSH_W-1:0]          dsh, rem_ext;
  logic                      ge;
  logic [QUO_W-1:0]          res;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:REG_LSB]);

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(width_q);
      REG_FRAME_HEIGHT: prdata = APB_DW'(height_q);
      REG_CORNER_UL:    prdata = corner_ul_q;
      REG_CORNER_UR:    prdata = corner_ur_q;
      REG_CORNER_LL:    prdata = corner_ll_q;
      REG_CORNER_LR:    prdata = corner_lr_q;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= RST_FRAME_WIDTH;
      height_q    <= RST_FRAME_HEIGHT;
      corner_ul_q <= RST_CORNER_UL;
      corner_ur_q <= RST_CORNER_UR;
      corner_ll_q <= RST_CORNER_LL;
      corner_lr_q <= RST_CORNER_LR;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  width_q     <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_q    <= pwdata[DIM_W-1:0];
        REG_CORNER_UL:    corner_ul_q <= pwdata;
        REG_CORNER_UR:    corner_ur_q <= pwdata;
        REG_CORNER_LL:    corner_ll_q <= pwdata;
        REG_CORNER_LR:    corner_lr_q <= pwdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame store
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign mem_we     = in_acc & (opcode_i == OP_LOAD);
  assign mem_re     = (state_q == S_READ);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_store_q[{pos_y_i, pos_x_i}] <= pixel_in_i;
    end
    if (mem_re) begin
      rd_data_q <= frame_store_q[{sy_q, sx_q}];
    end
  end

  // --------------------------------------------------------------------------
  // Arithmetic
  // --------------------------------------------------------------------------
  assign ul_s = corner_half(corner_ul_q, ax_q);
  assign ur_s = corner_half(corner_ur_q, ax_q);
  assign ll_s = corner_half(corner_ll_q, ax_q);
  assign lr_s = corner_half(corner_lr_q, ax_q);

  // I = ul*WH + (ur-ul)*Hx + (ll-ul)*Wy + ((lr-ll)-(ur-ul))*xy
  always_comb begin
    case (term_q)
      TERM_W'(0): begin
        coef_sel = COEF_W'(ul_s);
        fac_sel  = wh_q;
      end
      TERM_W'(1): begin
        coef_sel = COEF_W'(ur_s) - COEF_W'(ul_s);
        fac_sel  = hx_q;
      end
      TERM_W'(2): begin
        coef_sel = COEF_W'(ll_s) - COEF_W'(ul_s);
        fac_sel  = wy_q;
      end
      TERM_W'(3): begin
        coef_sel = (COEF_W'(lr_s) - COEF_W'(ll_s)) - (COEF_W'(ur_s) - COEF_W'(ul_s));
        fac_sel  = xy_q;
      end
      default: begin
        coef_sel = '0;
        fac_sel  = '0;
      end
    endcase
  end

  assign prod_mul = coef_q * $signed({1'b0, fac_q});

  // x divides by 65536*H, y by 65536*W
  assign d_div  = ax_q ? w_q : h_q;
  assign hi_lim = (ax_q ? h_q : w_q) - DIM_W'(1);

  // round half up on the magnitude, then drop the 16 fraction bits
  assign rnd = acc_q + ACC_W'({d_div, {(FRAC_W-1){1'b0}}});
  assign num = rnd[ACC_W-1:FRAC_W];
  assign sat = num >= NUM_W'({d_div, {QUO_W{1'b0}}});

  assign dsh     = DSH_W'(d_div) << cnt_q;
  assign rem_ext = DSH_W'(rem_q);
  assign ge      = rem_ext >= dsh;

  assign res = ({1'b0, quo_q} > hi_lim) ? hi_lim[QUO_W-1:0] : quo_q;

  assign out_load = (state_q == S_OUT) & (~out_valid_q | out_ready_i);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    term_d      = term_q;
    cnt_d       = cnt_q;
    w_d         = w_q;
    h_d         = h_q;
    x_d         = x_q;
    y_d         = y_q;
    wh_d        = wh_q;
    hx_d        = hx_q;
    wy_d        = wy_q;
    xy_d        = xy_q;
    fac_d       = fac_q;
    coef_d      = coef_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    pixel_out_d = pixel_out_q;
    source_x_d  = source_x_q;
    source_y_d  = source_y_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (opcode_i == OP_EMIT)) begin
          x_d  = pos_x_i;
          y_d  = pos_y_i;
          w_d  = sat_dim(width_q, MAX_W_DIM);
          h_d  = sat_dim(height_q, MAX_H_DIM);
          ax_d = 1'b0;
          // zero frame size: transaction dropped
          if (width_q != '0 && height_q != '0) begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        wh_d    = {{(FAC_W-DIM_W){1'b0}}, w_q} * {{(FAC_W-DIM_W){1'b0}}, h_q};
        hx_d    = {{(FAC_W-DIM_W){1'b0}}, h_q} * {{(FAC_W-COL_W){1'b0}}, x_q};
        wy_d    = {{(FAC_W-DIM_W){1'b0}}, w_q} * {{(FAC_W-ROW_W){1'b0}}, y_q};
        xy_d    = {{(FAC_W-COL_W){1'b0}}, x_q} * {{(FAC_W-ROW_W){1'b0}}, y_q};
        term_d  = '0;
        coef_d  = '0;
        fac_d   = '0;
        prod_d  = '0;
        acc_d   = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        // coef/factor -> product -> accumulate, one term per cycle
        coef_d = (term_q < TERM_COUNT) ? coef_sel : '0;
        fac_d  = fac_sel;
        prod_d = prod_mul;
        acc_d  = acc_q + ACC_W'(prod_q);
        term_d = term_q + TERM_W'(1);
        if (term_q == TERM_LAST) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (acc_q[ACC_W-1]) begin
          // negative source coordinate clamps to zero
          quo_d   = '0;
          state_d = S_CLAMP;
        end else if (sat) begin
          quo_d   = '1;
          state_d = S_CLAMP;
        end else begin
          rem_d   = num[REM_W-1:0];
          quo_d   = '0;
          cnt_d   = CNT_W'(QUO_W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (ge) begin
          rem_d        = REM_W'(rem_ext - dsh);
          quo_d[cnt_q] = 1'b1;
        end
        if (cnt_q == '0) begin
          state_d = S_CLAMP;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_CLAMP: begin
        if (!ax_q) begin
          sx_d    = res;
          ax_d    = 1'b1;
          term_d  = '0;
          coef_d  = '0;
          fac_d   = '0;
          prod_d  = '0;
          acc_d   = '0;
          state_d = S_MAC;
        end else begin
          sy_d    = res;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          pixel_out_d = rd_data_q;
          source_x_d  = sx_q;
          source_y_d  = sy_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ax_q        <= 1'b0;
      term_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      term_q      <= term_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q         <= w_d;
    h_q         <= h_d;
    x_q         <= x_d;
    y_q         <= y_d;
    wh_q        <= wh_d;
    hx_q        <= hx_d;
    wy_q        <= wy_d;
    xy_q        <= xy_d;
    fac_q       <= fac_d;
    coef_q      <= coef_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    sx_q        <= sx_d;
    sy_q        <= sy_d;
    pixel_out_q <= pixel_out_d;
    source_x_q  <= source_x_d;
    source_y_q  <= source_y_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign source_x_o  = source_x_q;
  assign source_y_o  = source_y_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_store_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re)
    else $error("frame store written and read in the same cycle");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_ext < (DSH_W'(d_div) << (cnt_q + 1))))
    else $error("divider remainder out of range");

  a_result_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (({1'b0, sx_q} < w_q) && ({1'b0, sy_q} < h_q)))
    else $error("sampled position outside active frame");

  a_zero_dim_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (opcode_i == OP_EMIT) && (width_q == '0 || height_q == '0))
      |=> (state_q == S_IDLE))
    else $error("emit with zero frame size was not dropped");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside output step");

endmodule

`default_nettype wire

>>> sim/corner_pin_bilinear_warp_unit_test.sv
// ----------------------------------------------------------------------------
// corner_pin_bilinear_warp_unit_test
// Self-checking bench for the corner-pin warp unit. Queued load and emit
// transactions are driven with random gaps. A local model of the bilinear
// mapping and of the frame store predicts each emit result, and every result
// is checked field by field. Register settings change between drained phases
// and cover identity, oversized, zero and extreme corner cases.
// ----------------------------------------------------------------------------
module corner_pin_bilinear_warp_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cpw_pkg::*;

  localparam int SETTLE_CYCLES = 64;   // covers the longest emit latency
  localparam int STALL_LIMIT   = 5000;

  typedef struct {
    op_e              op;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic [PIX_W-1:0] pixel;
  } warp_item_t;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] sx;
    logic [ROW_W-1:0] sy;
  } warp_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                opcode_i    = 1'b0;
  logic [COL_W-1:0]    pos_x_i     = '0;
  logic [ROW_W-1:0]    pos_y_i     = '0;
  logic [PIX_W-1:0]    pixel_in_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [PIX_W-1:0]    pixel_out_o;
  logic [COL_W-1:0]    source_x_o;
  logic [ROW_W-1:0]    source_y_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  logic [APB_DW-1:0]   pwdata      = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  warp_item_t          pending_items[$];
  warp_result_t        expected_pixels[$];
  warp_item_t          drive_item;
  warp_result_t        want;
  logic [63:0]         cfg_reg [6];
  logic [PIX_W-1:0]    frame_copy [STORE_DEPTH];
  bit                  loaded [STORE_DEPTH];
  logic [COL_W-1:0]    pred_x;
  logic [ROW_W-1:0]    pred_y;
  logic                in_taken = 1'b0;
  int                  send_idle_pct = 29;
  int                  recv_idle_pct = 55;
  int                  err_count = 0;
  int                  stall_cycles = 0;

  corner_pin_bilinear_warp_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .source_x_o  (source_x_o),
    .source_y_o  (source_y_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void flag_error(input string what);
    if (err_count < 10) begin
      $display("%s", what);
    end
    err_count++;
  endfunction

  // ---------------------------------------------------------------- mapping

  function automatic longint corner_part(input logic [63:0] c, input bit sel_y);
    return sel_y ? longint'($signed(c[63:32])) : longint'($signed(c[31:0]));
  endfunction

  // Exact bilinear numerator for one axis, in Q16.16 units scaled by W*H
  function automatic longint blend_axis(input bit sel_y, input longint w, input longint h,
                                        input longint x, input longint y);
    longint ul, ur, ll, lr;
    ul = corner_part(cfg_reg[REG_CORNER_UL], sel_y);
    ur = corner_part(cfg_reg[REG_CORNER_UR], sel_y);
    ll = corner_part(cfg_reg[REG_CORNER_LL], sel_y);
    lr = corner_part(cfg_reg[REG_CORNER_LR], sel_y);
    return w * h * ul + h * (ur - ul) * x + w * (ll - ul) * y
         + ((lr - ll) - (ur - ul)) * x * y;
  endfunction

  // ties away from zero; den is positive
  function automatic longint round_half_away(input longint num, input longint den);
    longint unsigned mag, q;
    if (num < 0) mag = -num;
    else mag = num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_coord(input longint v, input longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Returns 0 when the frame has no area, in which case no result is due
  function automatic bit map_to_source(input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y,
                                       output logic [COL_W-1:0] sx,
                                       output logic [ROW_W-1:0] sy);
    longint w, h;
    w = longint'(cfg_reg[REG_FRAME_WIDTH][DIM_W-1:0]);
    h = longint'(cfg_reg[REG_FRAME_HEIGHT][DIM_W-1:0]);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    sx = '0;
    sy = '0;
    if (w == 0 || h == 0) return 1'b0;
    sx = COL_W'(clamp_coord(round_half_away(blend_axis(1'b0, w, h, longint'(x), longint'(y)),
                                            65536 * h), w - 1));
    sy = ROW_W'(clamp_coord(round_half_away(blend_axis(1'b1, w, h, longint'(x), longint'(y)),
                                            65536 * w), h - 1));
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_load(input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y,
                                    input logic [PIX_W-1:0] pixel);
    warp_item_t it;
    it.op    = OP_LOAD;
    it.x     = x;
    it.y     = y;
    it.pixel = pixel;
    pending_items.push_back(it);
    loaded[{y, x}] = 1'b1;
  endfunction

  // An emit never samples an empty store entry: load the target first if needed
  function automatic void push_emit(input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
    warp_item_t       it;
    logic [COL_W-1:0] sx;
    logic [ROW_W-1:0] sy;
    if (map_to_source(x, y, sx, sy) && !loaded[{sy, sx}]) begin
      push_load(sx, sy, $urandom());
    end
    it.op    = OP_EMIT;
    it.x     = x;
    it.y     = y;
    it.pixel = $urandom();
    pending_items.push_back(it);
  endfunction

  function automatic logic [63:0] near_corner(input int bx, input int by);
    int cx, cy;
    cx = bx * 65536 + int'($urandom_range(32768)) - 16384;
    cy = by * 65536 + int'($urandom_range(32768)) - 16384;
    return {32'(cy), 32'(cx)};
  endfunction

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_random(input int n);
    repeat (n) begin
      if ($urandom_range(99) < 35) begin
        push_load(COL_W'($urandom()), ROW_W'($urandom()), $urandom());
      end else begin
        push_emit(COL_W'($urandom()), ROW_W'($urandom()));
      end
    end
    drain();
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    logic [APB_DW-1:0] rd;
    cfg_reg[idx] = val;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) << REG_LSB);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) begin
      flag_error($sformatf("register %s read back %h, expected %h", idx.name(), rd, val));
    end
  endtask

  task automatic configure(input logic [7:0] w, input logic [7:0] h,
                           input logic [63:0] ul, input logic [63:0] ur,
                           input logic [63:0] ll, input logic [63:0] lr);
    write_reg(REG_FRAME_WIDTH, 64'(w));
    write_reg(REG_FRAME_HEIGHT, 64'(h));
    write_reg(REG_CORNER_UL, ul);
    write_reg(REG_CORNER_UR, ur);
    write_reg(REG_CORNER_LL, ll);
    write_reg(REG_CORNER_LR, lr);
  endtask

  initial begin
    cfg_reg[REG_FRAME_WIDTH]  = 64'(RST_FRAME_WIDTH);
    cfg_reg[REG_FRAME_HEIGHT] = 64'(RST_FRAME_HEIGHT);
    cfg_reg[REG_CORNER_UL]    = RST_CORNER_UL;
    cfg_reg[REG_CORNER_UR]    = RST_CORNER_UR;
    cfg_reg[REG_CORNER_LL]    = RST_CORNER_LL;
    cfg_reg[REG_CORNER_LR]    = RST_CORNER_LR;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset mapping is the identity: corners, overwrite, pixel extremes
    push_load(0, 0, 32'h0000_0000);
    push_load(127, 127, 32'hFFFF_FFFF);
    push_load(127, 0, 32'hA5A5_A5A5);
    push_load(0, 127, 32'h5A5A_5A5A);
    push_load(64, 63, 32'h8000_0001);
    push_emit(0, 0);
    push_emit(127, 127);
    push_emit(127, 0);
    push_emit(0, 127);
    push_emit(64, 63);
    push_load(0, 0, 32'h1234_5678);
    push_emit(0, 0);
    push_emit(1, 2);
    run_random(25);

    configure(8'd128, 8'd128, near_corner(0, 0), near_corner(1, 0),
              near_corner(0, 1), near_corner(1, 1));
    run_random(20);
    // sender holds off here until everything is back
    run_random(20);

    // most negative and most positive Q16.16 halves
    configure(8'd1, 8'd128, {32'h8000_0000, 32'h8000_0000}, {32'h7FFF_FFFF, 32'h7FFF_FFFF},
              {32'h7FFF_FFFF, 32'h8000_0000}, {32'h8000_0000, 32'h7FFF_FFFF});
    run_random(25);

    send_idle_pct = 55;
    recv_idle_pct = 29;
    // oversized frame saturates to the store size
    configure(8'd255, 8'd200, near_corner(0, 0), near_corner(1, 0),
              near_corner(0, 1), near_corner(1, 1));
    run_random(30);

    // zero width or height: emits give nothing back
    configure(8'd0, 8'd37, RST_CORNER_UL, RST_CORNER_UR, RST_CORNER_LL, RST_CORNER_LR);
    push_emit(0, 0);
    push_emit(127, 127);
    run_random(15);
    write_reg(REG_FRAME_WIDTH, 64'd37);
    write_reg(REG_FRAME_HEIGHT, 64'd0);
    run_random(10);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // small frame, identity corners: requests past the edge extrapolate and clamp
    configure(8'd5, 8'd3, RST_CORNER_UL, RST_CORNER_UR, RST_CORNER_LL, RST_CORNER_LR);
    push_load(100, 90, 32'hC3C3_3C3C);
    push_emit(127, 127);
    push_emit(4, 2);
    run_random(30);

    for (int i = 0; i < 4; i++) begin
      if (i == 0) begin
        configure(8'd128, 8'd1, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  {$urandom(), $urandom()}, {$urandom(), $urandom()});
      end else if (i == 2) begin
        configure(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)),
                  {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  {$urandom(), $urandom()}, {$urandom(), $urandom()});
      end else begin
        configure(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)),
                  near_corner(0, 0), near_corner(1, 0), near_corner(0, 1), near_corner(1, 1));
      end
      run_random(28);
    end

    if (err_count == 0 && expected_pixels.size() == 0) begin
      $display("** corner_pin_bilinear_warp_unit: PASSED **");
    end else begin
      $display("** corner_pin_bilinear_warp_unit: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid_i || in_taken) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item = pending_items.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= drive_item.op;
          pos_x_i    <= drive_item.x;
          pos_y_i    <= drive_item.y;
          pixel_in_i <= drive_item.pixel;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          flag_error($sformatf("unexpected result: pixel %h src (%0d,%0d)",
                               pixel_out_o, source_x_o, source_y_o));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out_o !== want.pixel || source_x_o !== want.sx ||
              source_y_o !== want.sy) begin
            flag_error($sformatf("result mismatch: exp pixel %h src (%0d,%0d), got %h (%0d,%0d)",
                                 want.pixel, want.sx, want.sy,
                                 pixel_out_o, source_x_o, source_y_o));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (op_e'(opcode_i) == OP_LOAD) begin
          frame_copy[{pos_y_i, pos_x_i}] = pixel_in_i;
        end else if (map_to_source(pos_x_i, pos_y_i, pred_x, pred_y)) begin
          expected_pixels.push_back('{frame_copy[{pred_y, pred_x}], pred_x, pred_y});
        end
      end
    end
  end

  // no transaction on either channel for too long ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles < STALL_LIMIT) begin
      stall_cycles <= stall_cycles + 1;
    end else begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("** corner_pin_bilinear_warp_unit: FAILED **");
      $finish;
    end
  end

endmodule
